### hdl/mbrtu_pkg.sv
package mbrtu_pkg;

	localparam logic [7:0]  STATION_RESET = 8'h01;
	localparam logic [15:0] CRC_INIT      = 16'hFFFF;
	localparam logic [15:0] CRC_POLY      = 16'hA001;

	localparam int unsigned PADDR_W = 3;
	localparam logic [0:0]  REG_STATION = 1'b0;

	localparam logic [7:0] FC_READ_COILS    = 8'd1;
	localparam logic [7:0] FC_READ_DISCRETE = 8'd2;
	localparam logic [7:0] FC_READ_HOLDING  = 8'd3;
	localparam logic [7:0] FC_READ_INPUT    = 8'd4;
	localparam logic [7:0] FC_WRITE_COIL    = 8'd5;
	localparam logic [7:0] FC_WRITE_REG     = 8'd6;
	localparam logic [7:0] FC_WRITE_MULTI   = 8'd16;

	localparam logic OP_COMMAND = 1'b0;
	localparam logic OP_WORD    = 1'b1;

	// byte counts of each frame shape
	localparam logic [3:0] LEN_FIXED       = 4'd8;
	localparam logic [3:0] LEN_MULTI_OPEN  = 4'd7;
	localparam logic [3:0] LEN_MULTI_EMPTY = 4'd9;
	localparam logic [3:0] LEN_WORD        = 4'd2;
	localparam logic [3:0] LEN_WORD_LAST   = 4'd4;

	typedef enum logic [2:0] {
		KIND_NONE,
		KIND_READ,
		KIND_COIL,
		KIND_REG,
		KIND_MULTI,
		KIND_WORD
	} kind_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} byte_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

### hdl/modbus_rtu_request_framer.sv
// first byte of a frame: its item is registered in the sequencer, then the byte in the output register
// throughput: one frame byte per cycle while m_tready is high; an item has 8 bytes for
// codes 1 to 6, 7 or 9 for code 16, 2 or 4 for a data word, and none otherwise
// the byte sequencer is the limit: the next item is taken with the last byte of this one
// reset: arst_n clears the frame state, crc to all ones, station address to 1
module modbus_rtu_request_framer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// function_code[7:0], start_address[23:8], quantity[39:24], data_value[55:40]
	input  logic [55:0]                   s_tdata,
	// op
	input  logic                          s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// frame_byte[7:0]
	output logic [7:0]                    m_tdata,
	output logic                          m_tlast,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mbrtu_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	logic [7:0]       station_addr;
	logic             byte_valid;
	logic             byte_ready;
	mbrtu_pkg::byte_t byte_w;

	mbrtu_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.station (station_addr)
	);

	mbrtu_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.station    (station_addr),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_op      (s_tuser),
		.in_code    (s_tdata[7:0]),
		.in_addr    (s_tdata[23:8]),
		.in_qty     (s_tdata[39:24]),
		.in_val     (s_tdata[55:40]),
		.byte_valid (byte_valid),
		.byte_out   (byte_w),
		.byte_ready (byte_ready)
	);

	mbrtu_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_in    (byte_w),
		.byte_ready (byte_ready),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast)
	);

endmodule

### hdl/mbrtu_regs.sv
module mbrtu_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [mbrtu_pkg::PADDR_W-1:0]       paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready,
	output logic [7:0]                          station
);

	logic [7:0] station_q;
	logic       sel_station;

	assign pready      = 1'b1;
	assign sel_station = (paddr[mbrtu_pkg::PADDR_W-1] == mbrtu_pkg::REG_STATION);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			station_q <= mbrtu_pkg::STATION_RESET;
		end else if (psel && penable && pwrite && pready && sel_station) begin
			station_q <= pwdata[7:0];
		end
	end

	assign prdata  = sel_station ? {24'h000000, station_q} : 32'h00000000;
	assign station = station_q;

endmodule

### hdl/mbrtu_seq.sv
module mbrtu_seq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [7:0]           station,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 in_op,
	input  logic [7:0]           in_code,
	input  logic [15:0]          in_addr,
	input  logic [15:0]          in_qty,
	input  logic [15:0]          in_val,
	output logic                 byte_valid,
	output mbrtu_pkg::byte_t     byte_out,
	input  logic                 byte_ready
);

	// frame state
	logic [15:0]      crc_q;
	logic [15:0]      words_q;
	logic             phase_q;
	logic             busy_q;
	logic [3:0]       idx_q;

	// item held while its bytes go out
	mbrtu_pkg::kind_t kind_s1;
	logic [3:0]       len_s1;
	logic             with_crc_s1;
	logic [7:0]       code_s1;
	logic [15:0]      addr_s1;
	logic [15:0]      qty_s1;
	logic [15:0]      val_s1;

	mbrtu_pkg::kind_t plan_kind;
	logic [3:0]       plan_len;
	logic             plan_crc;

	logic             emit;
	logic             at_end;
	logic             accept;
	logic             crc_pos;
	logic             crc_hi;
	logic [7:0]       data_b;
	logic [15:0]      crc_nxt;

	assign emit     = busy_q & byte_ready;
	assign at_end   = (idx_q == len_s1 - 4'd1);
	assign in_ready = !busy_q || (emit && at_end);
	assign accept   = in_valid & in_ready;

	always_comb begin
		plan_kind = mbrtu_pkg::KIND_NONE;
		plan_len  = 4'd0;
		plan_crc  = 1'b0;
		if (in_op == mbrtu_pkg::OP_WORD) begin
			if (phase_q) begin
				plan_kind = mbrtu_pkg::KIND_WORD;
				plan_crc  = (words_q == 16'd1);
				plan_len  = plan_crc ? mbrtu_pkg::LEN_WORD_LAST : mbrtu_pkg::LEN_WORD;
			end
		end else begin
			unique case (in_code)
				mbrtu_pkg::FC_READ_COILS, mbrtu_pkg::FC_READ_DISCRETE,
				mbrtu_pkg::FC_READ_HOLDING, mbrtu_pkg::FC_READ_INPUT: begin
					plan_kind = mbrtu_pkg::KIND_READ;
					plan_len  = mbrtu_pkg::LEN_FIXED;
					plan_crc  = 1'b1;
				end
				mbrtu_pkg::FC_WRITE_COIL: begin
					plan_kind = mbrtu_pkg::KIND_COIL;
					plan_len  = mbrtu_pkg::LEN_FIXED;
					plan_crc  = 1'b1;
				end
				mbrtu_pkg::FC_WRITE_REG: begin
					plan_kind = mbrtu_pkg::KIND_REG;
					plan_len  = mbrtu_pkg::LEN_FIXED;
					plan_crc  = 1'b1;
				end
				mbrtu_pkg::FC_WRITE_MULTI: begin
					plan_kind = mbrtu_pkg::KIND_MULTI;
					plan_crc  = (in_qty == 16'd0);
					plan_len  = plan_crc ? mbrtu_pkg::LEN_MULTI_EMPTY
						: mbrtu_pkg::LEN_MULTI_OPEN;
				end
				default: begin
					plan_kind = mbrtu_pkg::KIND_NONE;
				end
			endcase
		end
	end

	// payload byte for the current position
	always_comb begin
		data_b = 8'h00;
		unique case (kind_s1)
			mbrtu_pkg::KIND_WORD: begin
				data_b = (idx_q == 4'd0) ? val_s1[15:8] : val_s1[7:0];
			end
			mbrtu_pkg::KIND_READ, mbrtu_pkg::KIND_COIL,
			mbrtu_pkg::KIND_REG, mbrtu_pkg::KIND_MULTI: begin
				unique case (idx_q)
					4'd0: data_b = station;
					4'd1: data_b = code_s1;
					4'd2: data_b = addr_s1[15:8];
					4'd3: data_b = addr_s1[7:0];
					4'd4: begin
						if (kind_s1 == mbrtu_pkg::KIND_REG) begin
							data_b = val_s1[15:8];
						end else if (kind_s1 == mbrtu_pkg::KIND_COIL) begin
							data_b = val_s1[7:0];
						end else begin
							data_b = qty_s1[15:8];
						end
					end
					4'd5: begin
						if (kind_s1 == mbrtu_pkg::KIND_REG) begin
							data_b = val_s1[7:0];
						end else if (kind_s1 == mbrtu_pkg::KIND_COIL) begin
							data_b = 8'h00;
						end else begin
							data_b = qty_s1[7:0];
						end
					end
					4'd6: data_b = {qty_s1[6:0], 1'b0};
					default: data_b = 8'h00;
				endcase
			end
			default: data_b = 8'h00;
		endcase
	end

	// the last two bytes of a closing frame carry the crc, low byte first
	assign crc_pos = with_crc_s1 && (idx_q >= len_s1 - 4'd2);
	assign crc_hi  = with_crc_s1 && at_end;

	assign byte_valid    = busy_q;
	assign byte_out.data = crc_pos ? (crc_hi ? crc_q[15:8] : crc_q[7:0]) : data_b;
	assign byte_out.last = crc_hi;

	always_comb begin
		crc_nxt = crc_q;
		if (emit) begin
			if (crc_hi) begin
				crc_nxt = mbrtu_pkg::CRC_INIT;
			end else if (!crc_pos) begin
				crc_nxt = mbrtu_pkg::crc_byte(crc_q, data_b);
			end
		end
		if (accept && (in_op == mbrtu_pkg::OP_COMMAND)) begin
			crc_nxt = mbrtu_pkg::CRC_INIT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q   <= mbrtu_pkg::CRC_INIT;
			words_q <= 16'd0;
			phase_q <= 1'b0;
			busy_q  <= 1'b0;
			idx_q   <= 4'd0;
			kind_s1     <= mbrtu_pkg::KIND_NONE;
			len_s1      <= 4'd0;
			with_crc_s1 <= 1'b0;
		end else begin
			crc_q <= crc_nxt;
			if (accept) begin
				busy_q      <= (plan_len != 4'd0);
				idx_q       <= 4'd0;
				kind_s1     <= plan_kind;
				len_s1      <= plan_len;
				with_crc_s1 <= plan_crc;
				if (in_op == mbrtu_pkg::OP_COMMAND) begin
					// a new command drops any open write-multiple phase
					if (plan_kind == mbrtu_pkg::KIND_MULTI && !plan_crc) begin
						words_q <= in_qty;
						phase_q <= 1'b1;
					end else begin
						words_q <= 16'd0;
						phase_q <= 1'b0;
					end
				end else if (phase_q) begin
					words_q <= words_q - 16'd1;
					phase_q <= (words_q != 16'd1);
				end
			end else if (emit) begin
				idx_q <= idx_q + 4'd1;
				if (at_end) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			code_s1 <= in_code;
			addr_s1 <= in_addr;
			qty_s1  <= in_qty;
			val_s1  <= in_val;
		end
	end

endmodule

### hdl/mbrtu_out.sv
module mbrtu_out (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             byte_valid,
	input  mbrtu_pkg::byte_t byte_in,
	output logic             byte_ready,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [7:0]       m_tdata,
	output logic             m_tlast
);

	logic             valid_q;
	mbrtu_pkg::byte_t byte_q;

	assign byte_ready = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (byte_ready) begin
			valid_q <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ready && byte_valid) begin
			byte_q <= byte_in;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = byte_q.data;
	assign m_tlast  = byte_q.last;

endmodule

### dv/modbus_rtu_request_framer_tb.sv
module modbus_rtu_request_framer_tb;

	localparam int STALL_LIMIT = 2000;
	localparam logic [mbrtu_pkg::PADDR_W-1:0] STATION_ADDR = {mbrtu_pkg::REG_STATION, 2'b00};

	typedef struct {
		logic        op;
		logic [7:0]  code;
		logic [15:0] addr;
		logic [15:0] qty;
		logic [15:0] val;
	} request_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} wire_byte_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	// function_code[7:0], start_address[23:8], quantity[39:24], data_value[55:40]
	logic [55:0]                   s_tdata = '0;
	// op
	logic                          s_tuser = 1'b0;
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	// frame_byte[7:0]
	logic [7:0]                    m_tdata;
	logic                          m_tlast;
	logic                          psel = 1'b0;
	logic                          penable = 1'b0;
	logic                          pwrite = 1'b0;
	logic [mbrtu_pkg::PADDR_W-1:0] paddr = '0;
	logic [31:0]                   pwdata = '0;
	logic [31:0]                   prdata;
	logic                          pready;

	// predicted framer state
	logic [7:0]          station_q;
	logic [15:0]         crc_run;
	logic [15:0]         words_due;
	logic                multi_open;

	wire_byte_t          frame_q[$];
	wire_byte_t          want;
	int                  errors = 0;
	int                  bytes_pushed = 0;
	int                  bytes_checked = 0;
	int                  items_sent = 0;
	int                  framing_items = 0;
	int                  station_writes = 0;
	int                  stall_cycles = 0;
	bit                  idle_en = 1'b1;

	modbus_rtu_request_framer uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #5 clk = ~clk;

	// bit-serial form of the reflected crc-16, lsb of the byte first
	function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		logic        fb;
		c = crc;
		for (int i = 0; i < 8; i++) begin
			fb = c[0] ^ b[i];
			c = c >> 1;
			if (fb) begin
				c = c ^ mbrtu_pkg::CRC_POLY;
			end
		end
		return c;
	endfunction

	task automatic push_byte(input logic [7:0] b);
		crc_run = crc_update(crc_run, b);
		frame_q.push_back('{data: b, last: 1'b0});
		bytes_pushed++;
	endtask

	task automatic push_word(input logic [15:0] w);
		push_byte(w[15:8]);
		push_byte(w[7:0]);
	endtask

	task automatic push_crc();
		frame_q.push_back('{data: crc_run[7:0], last: 1'b0});
		frame_q.push_back('{data: crc_run[15:8], last: 1'b1});
		bytes_pushed += 2;
		crc_run = mbrtu_pkg::CRC_INIT;
	endtask

	task automatic predict_request(input request_t r);
		int pushed_before;
		pushed_before = bytes_pushed;
		if (r.op == mbrtu_pkg::OP_WORD) begin
			if (multi_open) begin
				push_word(r.val);
				words_due = words_due - 16'd1;
				if (words_due == 16'd0) begin
					push_crc();
					multi_open = 1'b0;
				end
			end
		end else begin
			// any command drops an unfinished multi-register frame
			multi_open = 1'b0;
			words_due = '0;
			crc_run = mbrtu_pkg::CRC_INIT;
			case (r.code)
				mbrtu_pkg::FC_READ_COILS, mbrtu_pkg::FC_READ_DISCRETE,
				mbrtu_pkg::FC_READ_HOLDING, mbrtu_pkg::FC_READ_INPUT: begin
					push_byte(station_q);
					push_byte(r.code);
					push_word(r.addr);
					push_word(r.qty);
					push_crc();
				end
				mbrtu_pkg::FC_WRITE_COIL: begin
					push_byte(station_q);
					push_byte(r.code);
					push_word(r.addr);
					push_byte(r.val[7:0]);
					push_byte(8'h00);
					push_crc();
				end
				mbrtu_pkg::FC_WRITE_REG: begin
					push_byte(station_q);
					push_byte(r.code);
					push_word(r.addr);
					push_word(r.val);
					push_crc();
				end
				mbrtu_pkg::FC_WRITE_MULTI: begin
					push_byte(station_q);
					push_byte(r.code);
					push_word(r.addr);
					push_word(r.qty);
					push_byte({r.qty[6:0], 1'b0});
					if (r.qty == 16'd0) begin
						push_crc();
					end else begin
						words_due = r.qty;
						multi_open = 1'b1;
					end
				end
				default: ;
			endcase
		end
		if (bytes_pushed != pushed_before) begin
			framing_items++;
		end
	endtask

	// called and returns at a falling edge
	task automatic send_req(input logic op, input logic [7:0] code, input logic [15:0] addr,
			input logic [15:0] qty, input logic [15:0] val);
		request_t r;
		int       gap;
		r.op = op;
		r.code = code;
		r.addr = addr;
		r.qty = qty;
		r.val = val;
		gap = idle_en ? $urandom_range(0, 10) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {val, qty, addr, code};
		do @(posedge clk); while (!s_tready);
		predict_request(r);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_cmd(input logic [7:0] code, input logic [15:0] addr,
			input logic [15:0] qty, input logic [15:0] val);
		send_req(mbrtu_pkg::OP_COMMAND, code, addr, qty, val);
	endtask

	task automatic send_data(input logic [15:0] val);
		send_req(mbrtu_pkg::OP_WORD, 8'($urandom), 16'($urandom), 16'($urandom), val);
	endtask

	// wait until every predicted byte is out, then let a dropped item finish
	task automatic settle();
		s_tvalid <= 1'b0;
		while (frame_q.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic apb_write(input logic [mbrtu_pkg::PADDR_W-1:0] a, input logic [31:0] d);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= a;
		pwdata <= d;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic apb_read(input logic [mbrtu_pkg::PADDR_W-1:0] a, output logic [31:0] d);
		psel <= 1'b1;
		pwrite <= 1'b0;
		paddr <= a;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		d = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_station(input logic [7:0] v);
		logic [31:0] rd;
		settle();
		apb_write(STATION_ADDR, {24'h0, v});
		station_q = v;
		station_writes++;
		apb_read(STATION_ADDR, rd);
		if (rd[7:0] !== v) begin
			$error("station_address: expected %02h, got %02h", v, rd[7:0]);
			errors++;
		end
	endtask

	task automatic test_read_requests();
		send_cmd(mbrtu_pkg::FC_READ_COILS, 16'h0000, 16'h0000, 16'hFFFF);
		send_cmd(mbrtu_pkg::FC_READ_DISCRETE, 16'hFFFF, 16'hFFFF, 16'h0000);
		send_cmd(mbrtu_pkg::FC_READ_HOLDING, 16'h1234, 16'h000A, 16'($urandom));
		send_cmd(mbrtu_pkg::FC_READ_INPUT, 16'($urandom), 16'($urandom), 16'($urandom));
	endtask

	task automatic test_single_writes();
		// coil write keeps only the low byte of the value
		send_cmd(mbrtu_pkg::FC_WRITE_COIL, 16'h00AC, 16'hFFFF, 16'hFFFF);
		send_cmd(mbrtu_pkg::FC_WRITE_COIL, 16'hFFFF, 16'h0000, 16'h1200);
		send_cmd(mbrtu_pkg::FC_WRITE_REG, 16'h0000, 16'hFFFF, 16'h0000);
		send_cmd(mbrtu_pkg::FC_WRITE_REG, 16'hFFFF, 16'h0000, 16'hFFFF);
	endtask

	task automatic test_multi_write();
		// empty write closes at once
		send_cmd(mbrtu_pkg::FC_WRITE_MULTI, 16'h0010, 16'h0000, 16'h0000);
		send_cmd(mbrtu_pkg::FC_WRITE_MULTI, 16'h0020, 16'h0002, 16'h0000);
		send_data(16'hFFFF);
		send_data(16'h0000);
		// byte count wraps to zero, then a new command cuts the frame short
		send_cmd(mbrtu_pkg::FC_WRITE_MULTI, 16'hFFFF, 16'h0080, 16'hFFFF);
		send_data(16'hA55A);
		send_cmd(mbrtu_pkg::FC_READ_HOLDING, 16'h0001, 16'h0001, 16'h0000);
		// word with nothing open is dropped
		send_data(16'hBEEF);
	endtask

	task automatic test_unsupported_codes();
		send_cmd(8'd0, 16'($urandom), 16'($urandom), 16'($urandom));
		send_cmd(8'd7, 16'($urandom), 16'($urandom), 16'($urandom));
		send_cmd(8'd15, 16'($urandom), 16'($urandom), 16'($urandom));
		send_cmd(8'd255, 16'($urandom), 16'($urandom), 16'($urandom));
		send_cmd(mbrtu_pkg::FC_WRITE_MULTI, 16'h0100, 16'h0003, 16'h0000);
		send_data(16'h1111);
		send_cmd(8'd15, 16'h0000, 16'h0001, 16'h0000);
		send_data(16'h2222);
	endtask

	task automatic test_station_address();
		set_station(8'h00);
		send_cmd(mbrtu_pkg::FC_READ_HOLDING, 16'h0000, 16'h0001, 16'h0000);
		set_station(8'hFF);
		send_cmd(mbrtu_pkg::FC_WRITE_MULTI, 16'h0002, 16'h0001, 16'h0000);
		send_data(16'h5AA5);
		set_station(8'h01);
	endtask

	task automatic test_random_traffic();
		int          pick;
		int          nwords;
		int          next_phase;
		logic [7:0]  code;
		logic [15:0] qty;
		next_phase = items_sent + 30;
		while (items_sent < 220) begin
			if (items_sent >= next_phase) begin
				next_phase = items_sent + 30;
				pick = $urandom_range(0, 3);
				set_station(pick == 0 ? 8'h00 : pick == 1 ? 8'hFF : 8'($urandom));
				// every so often a stretch with no idling at all
				idle_en = ($urandom_range(0, 3) != 0);
			end
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				send_cmd(8'($urandom_range(1, 4)), 16'($urandom), 16'($urandom),
					16'($urandom));
			end else if (pick < 45) begin
				send_cmd(mbrtu_pkg::FC_WRITE_COIL, 16'($urandom), 16'($urandom),
					16'($urandom));
			end else if (pick < 60) begin
				send_cmd(mbrtu_pkg::FC_WRITE_REG, 16'($urandom), 16'($urandom),
					16'($urandom));
			end else if (pick < 85) begin
				qty = ($urandom_range(0, 9) != 0) ? 16'($urandom_range(1, 5)) :
					16'($urandom);
				send_cmd(mbrtu_pkg::FC_WRITE_MULTI, 16'($urandom), qty, 16'($urandom));
				nwords = (qty > 6) ? $urandom_range(0, 6) : int'(qty);
				if (nwords > 0 && $urandom_range(0, 6) == 0) begin
					nwords = $urandom_range(0, nwords - 1);
				end
				repeat (nwords) send_data(16'($urandom));
			end else if (pick < 93) begin
				case ($urandom_range(0, 2))
					0: code = 8'd0;
					1: code = 8'($urandom_range(7, 15));
					default: code = 8'($urandom_range(17, 255));
				endcase
				send_cmd(code, 16'($urandom), 16'($urandom), 16'($urandom));
			end else begin
				send_data(16'($urandom));
			end
		end
		idle_en = 1'b1;
	endtask

	// receiver: random hold-off before each transfer
	initial begin
		int n;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			n = idle_en ? $urandom_range(0, 10) : 0;
			if (n > 0) begin
				m_tready <= 1'b0;
				repeat (n) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			bytes_checked++;
			if (frame_q.size() == 0) begin
				$error("unexpected frame byte %02h, last %0b", m_tdata, m_tlast);
				errors++;
			end else begin
				want = frame_q.pop_front();
				if (m_tdata !== want.data) begin
					$error("frame_byte: expected %02h, got %02h", want.data, m_tdata);
					errors++;
				end
				if (m_tlast !== want.last) begin
					$error("last_byte: expected %0b, got %0b", want.last, m_tlast);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
		if (stall_cycles >= STALL_LIMIT) begin
			$display("timeout: %0d cycles with no transfer", stall_cycles);
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		station_q = mbrtu_pkg::STATION_RESET;
		crc_run = mbrtu_pkg::CRC_INIT;
		words_due = '0;
		multi_open = 1'b0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_read_requests();
		test_single_writes();
		test_multi_write();
		test_unsupported_codes();
		test_station_address();
		test_random_traffic();

		settle();
		repeat (20) @(negedge clk);
		if (frame_q.size() != 0) begin
			$error("%0d frame bytes never arrived", frame_q.size());
			errors++;
		end
		$display("sent %0d request items (%0d producing frame bytes), checked %0d bytes",
			items_sent, framing_items, bytes_checked);
		$display("station address rewritten %0d times across read, write and multi frames",
			station_writes);
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

### files.f
hdl/mbrtu_pkg.sv
hdl/mbrtu_regs.sv
hdl/mbrtu_seq.sv
hdl/mbrtu_out.sv
hdl/modbus_rtu_request_framer.sv
dv/modbus_rtu_request_framer_tb.sv
